// ===== rtl/lct_pkg.sv =====
// Shared types, constants and helpers for the LRU cache table.
package lct_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int STAT_W     = 32;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_PUT    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_SHIFT_L,
    ACT_SHIFT_R,
    ACT_CLR
  } cell_act_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                capture;
    logic [KEY_BITS-1:0] cmp_key;
  } lct_ctl_t;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    sat_inc = (&v) ? v : v + STAT_W'(1);
  endfunction

endpackage

// ===== rtl/lct_cell.sv =====
// One cell of the recency chain: holds one entry, compares the key, shifts to/from neighbors.
module lct_cell import lct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lct_ctl_t  ctl,
  input  cell_act_t act,
  input  entry_t    left_in,
  input  entry_t    right_in,
  output entry_t    ent_q,
  output logic      match_q
);

  entry_t ent_r, ent_nxt;
  logic   match_r, match_nxt;

  always_comb begin
    unique case (act)
      ACT_HOLD:    ent_nxt = ent_r;
      ACT_SHIFT_L: ent_nxt = left_in;
      ACT_SHIFT_R: ent_nxt = right_in;
      ACT_CLR: begin
        ent_nxt       = ent_r;
        ent_nxt.valid = 1'b0;
      end
      default:     ent_nxt = ent_r;
    endcase
  end

  always_comb begin
    match_nxt = match_r;
    if (ctl.capture) begin
      match_nxt = ent_r.valid && (ent_r.key == ctl.cmp_key);
    end
  end

  // key and value need no reset: they are only used behind the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      match_r     <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
      match_r     <= match_nxt;
    end
    ent_r.key   <= ent_nxt.key;
    ent_r.value <= ent_nxt.value;
  end

  assign ent_q   = ent_r;
  assign match_q = match_r;

endmodule

// ===== rtl/lru_cache_table.sv =====
// Top level of the fully associative LRU cache table built as a chain of entry cells.
//
//  port group | dir | handshake             | carries
//  in_*       | in  | in_valid / in_stall   | opcode, key, write_value
//  out_*      | out | out_valid / out_stall | lookup/eviction result, occupancy, stats
//  cfg_*      | in  | cfg_valid / cfg_ready | capacity
//
// The accept edge latches a key match in every cell; the update state then shifts the
// chain (cell 0 = most recent) and loads the output register.
// The next item is taken once the update is done; a result may still wait at the output.
// A stalled output holds the block in the update cycle until the output register frees.
// Synchronous reset empties all cells, zeroes the counters and sets capacity to 16.
module lru_cache_table import lct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_write_value,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [VALUE_BITS-1:0] out_read_value,
  output logic                  out_evicted,
  output logic [KEY_BITS-1:0]   out_evicted_key,
  output logic [VALUE_BITS-1:0] out_evicted_value,
  output logic [CNT_W-1:0]      out_occupancy,
  output logic [STAT_W-1:0]     out_get_count,
  output logic [STAT_W-1:0]     out_hit_count,
  output logic [STAT_W-1:0]     out_miss_count,
  output logic [STAT_W-1:0]     out_put_count,
  output logic [STAT_W-1:0]     out_evict_count,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_capacity
);

  state_t state_r, state_nxt;
  logic   in_acc, do_upd;

  op_t                   op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [CNT_W-1:0]      cap_r, cap_eff;
  logic [CNT_W-1:0]      total_r, total_nxt, total_m1, put_lim;

  logic [STAT_W-1:0] gets_r, hits_r, misses_r, puts_r, evicts_r;
  logic [STAT_W-1:0] gets_nxt, hits_nxt, misses_nxt, puts_nxt, evicts_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  found_r, evicted_r;
  logic [VALUE_BITS-1:0] read_val_r, ev_val_r;
  logic [KEY_BITS-1:0]   ev_key_r;
  logic [CNT_W-1:0]      occ_r;
  logic [STAT_W-1:0]     o_gets_r, o_hits_r, o_misses_r, o_puts_r, o_evicts_r;

  entry_t            ent_q    [ENTRIES];
  entry_t            left_in  [ENTRIES];
  entry_t            right_in [ENTRIES];
  cell_act_t         act      [ENTRIES];
  logic [ENTRIES-1:0] match_vec, valid_vec;
  lct_ctl_t          ctl;
  entry_t            ins_ent, empty_ent, ev_ent;

  logic                  hit, evict;
  logic [IDX_W-1:0]      hit_pos;
  logic [CNT_W-1:0]      hit_pos_c;
  logic [VALUE_BITS-1:0] hit_val;

  // ---------------- control FSM ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_UPD;
      ST_UPD:  if (do_upd) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    do_upd   = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_UPD:  do_upd   = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // ---------------- cell chain ----------------
  assign ctl.capture = in_acc;
  assign ctl.cmp_key = in_key;

  assign empty_ent = '0;

  always_comb begin
    hit     = |match_vec;
    hit_pos = '0;
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
        hit_val = hit_val | ent_q[i].value;
      end
    end
  end

  assign hit_pos_c = CNT_W'(hit_pos);

  always_comb begin
    cap_eff = cap_r;
    if (cap_r == '0) cap_eff = CNT_W'(1);
    else if (cap_r > CNT_W'(ENTRIES)) cap_eff = CNT_W'(ENTRIES);
  end

  assign total_m1 = total_r - CNT_W'(1);
  assign evict    = (op_r == OP_PUT) && !hit && (total_r >= cap_eff) && (total_r != '0);
  assign ev_ent   = ent_q[total_m1[IDX_W-1:0]];
  assign put_lim  = evict ? total_m1 : total_r;

  // entry that enters at the head of the chain
  always_comb begin
    ins_ent.valid = 1'b1;
    ins_ent.key   = key_r;
    ins_ent.value = (op_r == OP_GET) ? hit_val : val_r;
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      act[i] = ACT_HOLD;
      if (do_upd) begin
        case (op_r)
          OP_GET: begin
            if (hit && CNT_W'(i) <= hit_pos_c) act[i] = ACT_SHIFT_L;
          end
          OP_PUT: begin
            if (hit) begin
              if (CNT_W'(i) <= hit_pos_c) act[i] = ACT_SHIFT_L;
            end else if (CNT_W'(i) <= put_lim) begin
              act[i] = ACT_SHIFT_L;
            end
          end
          OP_REMOVE: begin
            if (hit && CNT_W'(i) >= hit_pos_c) act[i] = ACT_SHIFT_R;
          end
          OP_CLEAR: act[i] = ACT_CLR;
        endcase
      end
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_in[g] = ins_ent;
    end else begin : g_mid_l
      assign left_in[g] = ent_q[g-1];
    end
    if (g == ENTRIES - 1) begin : g_tail
      assign right_in[g] = empty_ent;
    end else begin : g_mid_r
      assign right_in[g] = ent_q[g+1];
    end

    lct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .act      (act[g]),
      .left_in  (left_in[g]),
      .right_in (right_in[g]),
      .ent_q    (ent_q[g]),
      .match_q  (match_vec[g])
    );

    assign valid_vec[g] = ent_q[g].valid;
  end

  // ---------------- occupancy and statistics ----------------
  always_comb begin
    total_nxt  = total_r;
    gets_nxt   = gets_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    puts_nxt   = puts_r;
    evicts_nxt = evicts_r;
    if (do_upd) begin
      case (op_r)
        OP_GET: begin
          gets_nxt = sat_inc(gets_r);
          if (hit) hits_nxt = sat_inc(hits_r);
          else     misses_nxt = sat_inc(misses_r);
        end
        OP_PUT: begin
          puts_nxt = sat_inc(puts_r);
          if (!hit) begin
            if (evict) evicts_nxt = sat_inc(evicts_r);
            else       total_nxt  = total_r + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (hit) total_nxt = total_m1;
        end
        OP_CLEAR: total_nxt = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_upd) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CNT_W'(ENTRIES);
      total_r     <= '0;
      gets_r      <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      puts_r      <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_capacity;
      total_r     <= total_nxt;
      gets_r      <= gets_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      puts_r      <= puts_nxt;
      evicts_r    <= evicts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= op_t'(in_opcode);
      key_r <= in_key;
      val_r <= in_write_value;
    end
    if (do_upd) begin
      found_r    <= hit && ((op_r == OP_GET) || (op_r == OP_REMOVE));
      read_val_r <= (hit && (op_r == OP_GET)) ? hit_val : '0;
      evicted_r  <= evict;
      ev_key_r   <= evict ? ev_ent.key : '0;
      ev_val_r   <= evict ? ev_ent.value : '0;
      occ_r      <= total_nxt;
      o_gets_r   <= gets_nxt;
      o_hits_r   <= hits_nxt;
      o_misses_r <= misses_nxt;
      o_puts_r   <= puts_nxt;
      o_evicts_r <= evicts_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_read_value    = read_val_r;
  assign out_evicted       = evicted_r;
  assign out_evicted_key   = ev_key_r;
  assign out_evicted_value = ev_val_r;
  assign out_occupancy     = occ_r;
  assign out_get_count     = o_gets_r;
  assign out_hit_count     = o_hits_r;
  assign out_miss_count    = o_misses_r;
  assign out_put_count     = o_puts_r;
  assign out_evict_count   = o_evicts_r;

  // ---------------- assertions ----------------
  // the number of valid cells in the chain matches the occupancy count
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(total_r))
    else $error("valid cells do not match occupancy");

  // no key may sit in two cells
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(match_vec))
    else $error("key matched in more than one cell");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(ENTRIES))
    else $error("occupancy above entry count");

  // an eviction always reports a live entry
  a_evict_live: assert property (@(posedge clk) disable iff (!rst_n)
    (do_upd && evict) |-> ev_ent.valid)
    else $error("evicting an empty cell");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the LRU cache table: directed and random traffic with a mirror.
`timescale 1ns / 100ps

module tb_top;
  import lct_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
    logic [VALUE_BITS-1:0] evicted_value;
    logic [CNT_W-1:0]      occupancy;
    logic [STAT_W-1:0]     gets;
    logic [STAT_W-1:0]     hits;
    logic [STAT_W-1:0]     misses;
    logic [STAT_W-1:0]     puts;
    logic [STAT_W-1:0]     evicts;
  } lookup_res_t;

  // Mirror of the cache contents and recency order; holds the results still owed.
  class cache_mirror;
    bit                    slot_live [ENTRIES];
    logic [KEY_BITS-1:0]   slot_key  [ENTRIES];
    logic [VALUE_BITS-1:0] slot_data [ENTRIES];
    logic [IDX_W-1:0]      slot_age  [ENTRIES];
    logic [CNT_W-1:0]      live_count;
    logic [CNT_W-1:0]      capacity;
    logic [STAT_W-1:0]     n_get, n_hit, n_miss, n_put, n_evict;
    lookup_res_t           due_results [$];
    int                    mismatches;

    function new();
      int i;
      for (i = 0; i < ENTRIES; i++) begin
        slot_live[i] = 1'b0;
        slot_key[i]  = '0;
        slot_data[i] = '0;
        slot_age[i]  = '0;
      end
      live_count = '0;
      capacity   = CNT_W'(ENTRIES);
      n_get = '0; n_hit = '0; n_miss = '0; n_put = '0; n_evict = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void set_capacity(logic [CNT_W-1:0] c);
      capacity = c;
    endfunction

    function logic [STAT_W-1:0] bump(logic [STAT_W-1:0] c);
      return (&c) ? c : c + STAT_W'(1);
    endfunction

    function int lookup(logic [KEY_BITS-1:0] k);
      int i, hit;
      hit = -1;
      for (i = 0; i < ENTRIES; i++)
        if (hit < 0 && slot_live[i] && slot_key[i] == k) hit = i;
      return hit;
    endfunction

    // entries more recent than s age by one, s becomes most recent
    function void promote(int s);
      int i;
      logic [IDX_W-1:0] r;
      r = slot_age[s];
      for (i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = '0;
    endfunction

    function void retire(int s);
      int i;
      logic [IDX_W-1:0] r;
      r = slot_age[s];
      slot_live[s] = 1'b0;
      slot_age[s]  = '0;
      for (i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_age[i] > r) slot_age[i]--;
      if (live_count > 0) live_count--;
    endfunction

    function void note_request(op_t op, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
      lookup_res_t r;
      int s, i, lim, victim, free;
      r = '0;
      lim = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : int'(capacity));
      case (op)
        OP_GET: begin
          n_get = bump(n_get);
          s = lookup(k);
          if (s < 0) begin
            n_miss = bump(n_miss);
          end else begin
            n_hit = bump(n_hit);
            promote(s);
            r.found      = 1'b1;
            r.read_value = slot_data[s];
          end
        end
        OP_PUT: begin
          n_put = bump(n_put);
          s = lookup(k);
          if (s >= 0) begin
            slot_data[s] = v;
            promote(s);
          end else begin
            // only one victim, even when capacity dropped below occupancy
            if (int'(live_count) >= lim && live_count > 0) begin
              victim = -1;
              for (i = 0; i < ENTRIES; i++)
                if (victim < 0 && slot_live[i] && int'(slot_age[i]) == int'(live_count) - 1)
                  victim = i;
              if (victim >= 0) begin
                r.evicted       = 1'b1;
                r.evicted_key   = slot_key[victim];
                r.evicted_value = slot_data[victim];
                retire(victim);
                n_evict = bump(n_evict);
              end
            end
            free = -1;
            for (i = 0; i < ENTRIES; i++)
              if (free < 0 && !slot_live[i]) free = i;
            if (free >= 0) begin
              for (i = 0; i < ENTRIES; i++)
                if (slot_live[i]) slot_age[i]++;
              slot_live[free] = 1'b1;
              slot_key[free]  = k;
              slot_data[free] = v;
              slot_age[free]  = '0;
              live_count++;
            end
          end
        end
        OP_REMOVE: begin
          s = lookup(k);
          if (s >= 0) begin
            retire(s);
            r.found = 1'b1;
          end
        end
        OP_CLEAR: begin
          for (i = 0; i < ENTRIES; i++) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = '0;
          end
          live_count = '0;
        end
      endcase
      r.occupancy = live_count;
      r.gets      = n_get;
      r.hits      = n_hit;
      r.misses    = n_miss;
      r.puts      = n_put;
      r.evicts    = n_evict;
      due_results.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t ns %s: expected %h, got %h", $time, field, want, got);
      end
    endfunction

    function void check_response(lookup_res_t got);
      lookup_res_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t ns result with no item pending, occupancy %0d", $time, got.occupancy);
        return;
      end
      want = due_results.pop_front();
      compare("found",         32'(want.found),     32'(got.found));
      compare("read_value",    want.read_value,     got.read_value);
      compare("evicted",       32'(want.evicted),   32'(got.evicted));
      compare("evicted_key",   want.evicted_key,    got.evicted_key);
      compare("evicted_value", want.evicted_value,  got.evicted_value);
      compare("occupancy",     32'(want.occupancy), 32'(got.occupancy));
      compare("get_count",     want.gets,           got.gets);
      compare("hit_count",     want.hits,           got.hits);
      compare("miss_count",    want.misses,         got.misses);
      compare("put_count",     want.puts,           got.puts);
      compare("evict_count",   want.evicts,         got.evicts);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_opcode;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_write_value;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_found;
  logic [VALUE_BITS-1:0] out_read_value;
  logic                  out_evicted;
  logic [KEY_BITS-1:0]   out_evicted_key;
  logic [VALUE_BITS-1:0] out_evicted_value;
  logic [CNT_W-1:0]      out_occupancy;
  logic [STAT_W-1:0]     out_get_count;
  logic [STAT_W-1:0]     out_hit_count;
  logic [STAT_W-1:0]     out_miss_count;
  logic [STAT_W-1:0]     out_put_count;
  logic [STAT_W-1:0]     out_evict_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CNT_W-1:0]      cfg_capacity;

  cache_mirror sb;
  int          idle_odds;
  int          quiet_cycles = 0;

  lru_cache_table u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_key            (in_key),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_read_value    (out_read_value),
    .out_evicted       (out_evicted),
    .out_evicted_key   (out_evicted_key),
    .out_evicted_value (out_evicted_value),
    .out_occupancy     (out_occupancy),
    .out_get_count     (out_get_count),
    .out_hit_count     (out_hit_count),
    .out_miss_count    (out_miss_count),
    .out_put_count     (out_put_count),
    .out_evict_count   (out_evict_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_capacity      (cfg_capacity)
  );

  always #2 clk = ~clk;

  // monitors: everything is sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready)
      sb.set_capacity(cfg_capacity);
    if (rst_n && in_valid && !in_stall)
      sb.note_request(op_t'(in_opcode), in_key, in_write_value);
    if (rst_n && out_valid && !out_stall)
      sb.check_response({out_found, out_read_value, out_evicted, out_evicted_key,
                         out_evicted_value, out_occupancy, out_get_count, out_hit_count,
                         out_miss_count, out_put_count, out_evict_count});
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                  (cfg_valid && cfg_ready)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("lru_cache_table verification failed");
      $finish;
    end
  end

  // result side back-pressure in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(op_t op, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
    if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_key         <= k;
    in_write_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic drain(int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] c);
    drain(4);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(logic [CNT_W-1:0] cap, int n_items, int odds, bit mid_pause);
    logic [KEY_BITS-1:0] pool [$];
    logic [KEY_BITS-1:0] k;
    int pool_n, eff, n, pick;
    op_t op;
    write_capacity(cap);
    idle_odds = odds;
    eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap));
    // a key pool a little larger than the capacity keeps hits and evictions frequent
    pool_n = eff + $urandom_range(1, 8);
    for (n = 0; n < pool_n; n++) pool.push_back($urandom);
    for (n = 0; n < n_items; n++) begin
      if (mid_pause && n == n_items / 2) drain(0);
      pick = $urandom_range(0, 99);
      if (pick < 42)      op = OP_GET;
      else if (pick < 84) op = OP_PUT;
      else if (pick < 99) op = OP_REMOVE;
      else                op = OP_CLEAR;
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = pool[$urandom_range(0, pool_n - 1)];
      send_item(op, k, $urandom);
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_GET;
    in_key         = '0;
    in_write_value = '0;
    cfg_valid      = 1'b0;
    cfg_capacity   = '0;
    idle_odds      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_odds = 15;
    // empty store, key and value extremes, update in place, remove, clear
    send_item(OP_GET,    32'h0000_0000, 32'h1234_5678);
    send_item(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_PUT,    32'h0000_0000, 32'h0000_0000);
    send_item(OP_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_GET,    32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_PUT,    32'h0000_0000, 32'hA5A5_A5A5);
    send_item(OP_GET,    32'h0000_0000, 32'h5A5A_5A5A);
    send_item(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_CLEAR,  32'hDEAD_BEEF, 32'hCAFE_F00D);
    send_item(OP_GET,    32'h0000_0000, 32'h0000_0000);

    // capacity zero acts as one
    write_capacity(5'd0);
    send_item(OP_PUT, 32'h0000_0001, 32'h1111_1111);
    send_item(OP_PUT, 32'h0000_0002, 32'h2222_2222);
    send_item(OP_GET, 32'h0000_0002, 32'h0000_0000);
    send_item(OP_GET, 32'h0000_0001, 32'h0000_0000);

    // a get refreshes recency, so the other entry is the victim
    write_capacity(5'd2);
    send_item(OP_PUT, 32'h0000_0003, 32'h3333_3333);
    send_item(OP_PUT, 32'h0000_0004, 32'h4444_4444);
    send_item(OP_GET, 32'h0000_0003, 32'h0000_0000);
    send_item(OP_PUT, 32'h0000_0005, 32'h5555_5555);
    send_item(OP_PUT, 32'h0000_0003, 32'h3030_3030);

    // random phases; capacity changes without clearing, so it often drops below occupancy
    run_random(5'd16,  220, 25, 1'b0);
    run_random(5'd5,   160, 0,  1'b0);
    run_random(5'd31,  220, 8,  1'b1);
    run_random(5'd1,   120, 25, 1'b0);
    run_random(5'd0,   100, 8,  1'b0);
    run_random(CNT_W'($urandom_range(2, 15)),  200, 0,  1'b0);
    run_random(CNT_W'($urandom_range(17, 30)), 160, 25, 1'b0);
    run_random(5'd16,  220, 0,  1'b0);

    drain(16);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("lru_cache_table verification clean");
    end else begin
      $display("lru_cache_table verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lct_pkg.sv
rtl/lct_cell.sv
rtl/lru_cache_table.sv
tb/sv/tb_top.sv
